### rtl/button_click_classifier_assert.svh
// Assertion macros used by the checker file.
`ifndef BUTTON_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BCC_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### rtl/bcc_pkg.sv
package bcc_pkg;

  localparam int DEBOUNCE_W  = 10;
  localparam int WINDOW_W    = 12;
  localparam int COUNT_W     = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic [DEBOUNCE_W-1:0]  DEBOUNCE_RESET = 10'd10;
  localparam logic [WINDOW_W-1:0]    WINDOW_RESET   = 12'd500;
  localparam logic [COUNT_W-1:0]     MAX_CLICKS     = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLICK_WINDOW_TICKS = 2'd1;

  typedef enum logic [2:0] {
    CS_UNKNOWN         = 3'd0,
    CS_SINGLE_PRESSED  = 3'd1,
    CS_SINGLE_RELEASED = 3'd2,
    CS_DOUBLE_PRESSED  = 3'd3,
    CS_DOUBLE_RELEASED = 3'd4
  } click_state_t;

  typedef struct packed {
    logic pressed;
    logic ack;
  } bcc_in_t;

  typedef struct packed {
    logic [2:0] click_state;
    logic       processed;
  } bcc_out_t;

  typedef struct packed {
    logic                  last_level;
    logic [DEBOUNCE_W-1:0] debounce_left;
    logic                  debounce_running;
    logic [WINDOW_W-1:0]   window_left;
    logic                  window_running;
    logic [COUNT_W-1:0]    click_count;
    click_state_t          settled_state;
    logic                  done_flag;
  } bcc_state_t;

  localparam bcc_state_t STATE_RESET = '{
    last_level:       1'b0,
    debounce_left:    '0,
    debounce_running: 1'b0,
    window_left:      '0,
    window_running:   1'b0,
    click_count:      '0,
    settled_state:    CS_UNKNOWN,
    done_flag:        1'b0
  };

endpackage

### rtl/bcc_step.sv
// Next-state logic for one tick: debounce, click counting, window expiry, acknowledge.
module bcc_step (
  input  bcc_pkg::bcc_state_t                 cur,
  input  bcc_pkg::bcc_in_t                    req,
  input  logic [bcc_pkg::DEBOUNCE_W-1:0]      debounce_ticks,
  input  logic [bcc_pkg::WINDOW_W-1:0]        click_window_ticks,
  output bcc_pkg::bcc_state_t                 nxt
);

  // A zero load behaves as one
  function automatic logic [bcc_pkg::DEBOUNCE_W-1:0] load_db(
    input logic [bcc_pkg::DEBOUNCE_W-1:0] v);
    return (v == '0) ? bcc_pkg::DEBOUNCE_W'(1) : v;
  endfunction

  function automatic logic [bcc_pkg::WINDOW_W-1:0] load_win(
    input logic [bcc_pkg::WINDOW_W-1:0] v);
    return (v == '0) ? bcc_pkg::WINDOW_W'(1) : v;
  endfunction

  function automatic bcc_pkg::click_state_t release_after(input bcc_pkg::click_state_t s);
    return (s == bcc_pkg::CS_SINGLE_PRESSED) ? bcc_pkg::CS_SINGLE_RELEASED
                                             : bcc_pkg::CS_DOUBLE_RELEASED;
  endfunction

  always_comb begin
    bcc_pkg::bcc_state_t n;
    logic                reload;
    n      = cur;
    reload = 1'b0;

    // Debounce: level change restarts, steady level counts down
    if (req.pressed != cur.last_level) begin
      n.last_level       = req.pressed;
      n.debounce_left    = load_db(debounce_ticks);
      n.debounce_running = 1'b1;
    end else if (cur.debounce_running) begin
      n.debounce_left = cur.debounce_left - bcc_pkg::DEBOUNCE_W'(1);
      if (n.debounce_left == '0) begin
        n.debounce_running = 1'b0;
        if (req.pressed) begin
          if (cur.click_count < bcc_pkg::MAX_CLICKS) begin
            n.click_count    = cur.click_count + bcc_pkg::COUNT_W'(1);
            n.window_left    = load_win(click_window_ticks);
            n.window_running = 1'b1;
            reload           = 1'b1;
          end
        end else if (cur.click_count == '0) begin
          n.settled_state = release_after(cur.settled_state);
        end
      end
    end

    // Click window; a reload this tick wins over expiry
    if (n.window_running && !reload) begin
      n.window_left = n.window_left - bcc_pkg::WINDOW_W'(1);
      if (n.window_left == '0) begin
        n.window_running = 1'b0;
        if (req.pressed) begin
          if (n.click_count == 2'd1) begin
            n.settled_state = bcc_pkg::CS_SINGLE_PRESSED;
          end else if (n.click_count >= bcc_pkg::MAX_CLICKS) begin
            n.settled_state = bcc_pkg::CS_DOUBLE_PRESSED;
          end
        end else begin
          if (n.click_count == '0) begin
            n.settled_state = release_after(n.settled_state);
          end else if (n.click_count == 2'd1) begin
            n.settled_state = bcc_pkg::CS_SINGLE_RELEASED;
          end else begin
            n.settled_state = bcc_pkg::CS_DOUBLE_RELEASED;
          end
        end
        n.done_flag   = 1'b0;
        n.click_count = '0;
      end
    end

    // Acknowledge applies last
    if (req.ack) begin
      n.done_flag = 1'b1;
    end

    nxt = n;
  end

endmodule

### rtl/bcc_out_reg.sv
// Result register: holds a result until taken, refills in the same cycle.
module bcc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bcc_pkg::bcc_out_t res,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bcc_pkg::bcc_out_t out_data
);

  assign in_ready = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

endmodule

### rtl/button_click_classifier.sv
// Button click classifier for one button: each request carries one tick's raw
// level and an acknowledge; each request yields exactly one result, the
// settled click state and processed flag after that tick. A request is taken
// every cycle (one request per clock sustained) while the result register is
// empty or being drained; the result appears in the cycle after acceptance. The
// rate is set by the combinational update of the debounce and click-window
// counters. Configuration writes (debounce ticks, click window ticks) apply to
// later countdown loads; indexes other than the two registers are ignored.
module button_click_classifier (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bcc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bcc_pkg::bcc_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bcc_pkg::bcc_out_t                  out_data
);

  logic [bcc_pkg::DEBOUNCE_W-1:0] debounce_ticks;
  logic [bcc_pkg::WINDOW_W-1:0]   click_window_ticks;
  bcc_pkg::bcc_state_t            state;
  bcc_pkg::bcc_state_t            state_next;
  bcc_pkg::bcc_out_t              res;
  logic                           accept;

  assign accept = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks     <= bcc_pkg::DEBOUNCE_RESET;
      click_window_ticks <= bcc_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcc_pkg::REG_DEBOUNCE_TICKS: begin
          debounce_ticks <= cfg_data[bcc_pkg::DEBOUNCE_W-1:0];
        end
        bcc_pkg::REG_CLICK_WINDOW_TICKS: begin
          click_window_ticks <= cfg_data[bcc_pkg::WINDOW_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  bcc_step u_step (
    .cur                (state),
    .req                (in_data),
    .debounce_ticks     (debounce_ticks),
    .click_window_ticks (click_window_ticks),
    .nxt                (state_next)
  );

  // Classifier state advances once per accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcc_pkg::STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  assign res.click_state = state_next.settled_state;
  assign res.processed   = state_next.done_flag;

  bcc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res       (res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/bcc_checker.sv
`include "button_click_classifier_assert.svh"

// Port-level checks on the classifier.
module bcc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input bcc_pkg::bcc_in_t                in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input bcc_pkg::bcc_out_t               out_data
);

  // A stalled result holds
  `BCC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(out_data), "stalled result changed")

  // Every accepted request gives a result next cycle
  `BCC_ASSERT_NEXT(a_result_follows, clk, rst, in_valid && in_ready, out_valid,
                   "result missing after request")

  // No result appears without a request
  `BCC_ASSERT_NEXT(a_no_invent, clk, rst,
                   !(in_valid && in_ready) && !(out_valid && !out_ready), !out_valid,
                   "result without request")

  // Ready whenever the result register is free or draining
  `BCC_ASSERT_NOW(a_ready_free, clk, rst, !out_valid || out_ready, in_ready,
                  "request blocked with free result register")

  // Acknowledge always reads back as processed
  `BCC_ASSERT_NEXT(a_ack_processed, clk, rst, in_valid && in_ready && in_data.ack,
                   out_data.processed, "acknowledge not reflected")

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (.*);
